@@ rtl/core/vector3_normalize_unit_assert.svh @@
// Assertion macros for the vector normalize unit checker.
// Included by the checker file; no other dependencies.
`ifndef VECTOR3_NORMALIZE_UNIT_ASSERT_SVH
`define VECTOR3_NORMALIZE_UNIT_ASSERT_SVH
// implication check under reset
`define V3N_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle check under reset
`define V3N_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

@@ rtl/core/v3n_pkg.sv @@
// Package for the vector normalize unit: widths and stage counts.
// No dependencies.
`timescale 1ns / 1ps
package v3n_pkg;
   localparam int COMPONENT_BITS = 24;
   localparam int CompW   = 24;
   localparam int UnitW   = 16;
   localparam int MagW    = 24;
   localparam int FracW   = 14;
   localparam int AbsW    = COMPONENT_BITS;
   localparam int SqW     = 2 * AbsW + 2;
   localparam int RootW   = AbsW + 1;
   localparam int DivQW   = FracW + 2;
   localparam int DivNW   = AbsW + FracW;
endpackage

@@ rtl/core/v3n_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
module v3n_sqrt import v3n_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [SqW-1:0]   radicand,
   output logic [RootW-1:0] root
);
   logic [SqW-1:0]   rem_ff  [RootW+1];
   logic [RootW-1:0] res_ff  [RootW+1];

   assign rem_ff[0] = radicand;
   assign res_ff[0] = '0;

   for (genvar s = 0; s < RootW; s++) begin : g_stage
      localparam int B = RootW - 1 - s;
      logic [SqW-1:0]   rem_in;
      logic [RootW-1:0] res_in;
      logic [SqW+1:0]   trial;
      logic [SqW-1:0]   rem_q;
      logic [RootW-1:0] res_q;
      always_comb begin
         trial = ({2'b0, res_ff[s]} << (B + 1)) | ({{SqW+1{1'b0}}, 1'b1} << (2 * B));
         if ({2'b0, rem_ff[s]} >= trial) begin
            rem_in = rem_ff[s] - trial[SqW-1:0];
            res_in = res_ff[s] | (RootW'(1) << B);
         end else begin
            rem_in = rem_ff[s];
            res_in = res_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_q <= rem_in;
            res_q <= res_in;
         end
      end
      assign rem_ff[s+1] = rem_q;
      assign res_ff[s+1] = res_q;
   end

   assign root = res_ff[RootW];
endmodule

@@ rtl/core/v3n_div_lane.sv @@
// One lane: pipelined restoring divide of |c|<<14 by the length, with sign.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
module v3n_div_lane import v3n_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [AbsW-1:0]  mag_abs,
   input  logic             neg,
   input  logic [RootW-1:0] len,
   output logic [UnitW-1:0] unit
);
   logic [RootW:0]   rem_w  [DivQW+1];
   logic [DivQW-1:0] q_w    [DivQW+1];
   logic [RootW-1:0] d_w    [DivQW+1];
   logic             n_w    [DivQW+1];

   // |c| <= len so quotient fits 15 bits; dividend = a * 2^14
   assign rem_w[0] = '0;
   assign q_w[0]   = '0;
   assign d_w[0]   = len;
   assign n_w[0]   = neg;

   for (genvar s = 0; s < DivQW; s++) begin : g_stage
      logic [RootW:0]   rem_in, rem_ff;
      logic [DivQW-1:0] q_in, q_ff;
      logic [RootW-1:0] d_ff;
      logic             n_ff;
      logic [RootW+1:0] sh;
      always_comb begin
         // first stage loads integer part; rest shift in zero bits
         if (s == 0) sh = {2'b0, {(RootW-AbsW){1'b0}}, mag_abs};
         else        sh = {rem_w[s], 1'b0};
         if (sh >= {2'b0, d_w[s]}) begin
            rem_in = (RootW+1)'(sh - {2'b0, d_w[s]});
            q_in   = {q_w[s][DivQW-2:0], 1'b1};
         end else begin
            rem_in = sh[RootW:0];
            q_in   = {q_w[s][DivQW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            d_ff   <= d_w[s];
            n_ff   <= n_w[s];
         end
      end
      assign rem_w[s+1] = rem_ff;
      assign q_w[s+1]   = q_ff;
      assign d_w[s+1]   = d_ff;
      assign n_w[s+1]   = n_ff;
   end

   // 16 stages: 1 integer + 15 fraction bits, quotient is Q1.14 shifted by 1
   logic [DivQW-1:0] q_fin;
   assign q_fin = q_w[DivQW] >> 1;
   assign unit  = n_w[DivQW] ? UnitW'(-q_fin) : UnitW'(q_fin);
endmodule

@@ rtl/core/vector3_normalize_unit.sv @@
// Top level of the vector normalize unit: squares, sqrt, three divide lanes.
// Depends on v3n_pkg, v3n_sqrt, v3n_div_lane.
//
// Usage:
//   req_valid/req_ready carry one vector (comp_x, comp_y, comp_z, Q12.12).
//   rsp_valid/rsp_ready return unit_x/y/z (Q1.14), magnitude (Q12.12) and
//   zero_length for each request, in order.
//   Throughput: one request per cycle while the receiver does not stall.
//   Stages: 1 square stage + 1 sum stage + 25 square-root stages +
//   16 divide stages + output register; root and quotient take a bit per stage.
//   The three divide lanes run in parallel on the shared length; the merge
//   stage applies the zero-length case and packs the result.
//   The whole pipeline advances only when the output register is free or
//   being taken; when the receiver stalls, requests back up and req_ready
//   falls, nothing is dropped.
//   Reset clears all valid bits; payload registers are not reset.
//
`timescale 1ns / 1ps
module vector3_normalize_unit import v3n_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [CompW-1:0] req_comp_x,
   input  logic signed [CompW-1:0] req_comp_y,
   input  logic signed [CompW-1:0] req_comp_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [UnitW-1:0] rsp_unit_x,
   output logic signed [UnitW-1:0] rsp_unit_y,
   output logic signed [UnitW-1:0] rsp_unit_z,
   output logic [MagW-1:0]         rsp_magnitude,
   output logic                    rsp_zero_length
);
   localparam int Depth = 2 + RootW + DivQW;

   logic en;
   logic [Depth-1:0] vld_ff, vld_in;
   logic out_vld_ff;

   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[Depth-1];
      end
   end

   // stage 1: abs and square
   logic [AbsW-1:0] ab_in [3];
   logic            ng_in [3];
   logic [CompW-1:0] raw [3];
   assign raw[0] = req_comp_x;
   assign raw[1] = req_comp_y;
   assign raw[2] = req_comp_z;

   logic [AbsW-1:0]   ab_ff [3];
   logic              ng_ff [3];
   logic [2*AbsW-1:0] sq_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_sq
      logic [AbsW-1:0] c;
      assign c = raw[i][AbsW-1:0];
      assign ng_in[i] = c[AbsW-1];
      assign ab_in[i] = c[AbsW-1] ? AbsW'(-c) : c;
      always_ff @(posedge clock) begin
         if (en) begin
            ab_ff[i] <= ab_in[i];
            ng_ff[i] <= ng_in[i];
            sq_ff[i] <= ab_in[i] * ab_in[i];
         end
      end
   end

   // stage 2: sum
   logic [SqW-1:0]  sum_ff;
   logic [AbsW-1:0] ab2_ff [3];
   logic            ng2_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= SqW'(sq_ff[0]) + SqW'(sq_ff[1]) + SqW'(sq_ff[2]);
         for (int i = 0; i < 3; i++) begin
            ab2_ff[i] <= ab_ff[i];
            ng2_ff[i] <= ng_ff[i];
         end
      end
   end

   logic [RootW-1:0] root;
   v3n_sqrt u_sqrt (.clock(clock), .en(en), .radicand(sum_ff), .root(root));

   // delay components alongside the root pipeline
   logic [AbsW-1:0] abd_ff [RootW][3];
   logic            ngd_ff [RootW][3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            abd_ff[0][i] <= ab2_ff[i];
            ngd_ff[0][i] <= ng2_ff[i];
            for (int k = 1; k < RootW; k++) begin
               abd_ff[k][i] <= abd_ff[k-1][i];
               ngd_ff[k][i] <= ngd_ff[k-1][i];
            end
         end
      end
   end

   logic [UnitW-1:0] unit [3];
   logic [RootW-1:0] len_safe;
   assign len_safe = (root == '0) ? RootW'(1) : root;
   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3n_div_lane u_lane (
         .clock(clock), .en(en), .mag_abs(abd_ff[RootW-1][i]),
         .neg(ngd_ff[RootW-1][i]), .len(len_safe), .unit(unit[i]));
   end

   logic [RootW-1:0] lend_ff [DivQW];
   always_ff @(posedge clock) begin
      if (en) begin
         lend_ff[0] <= root;
         for (int k = 1; k < DivQW; k++) lend_ff[k] <= lend_ff[k-1];
      end
   end

   // merge stage
   logic zl;
   assign zl = (lend_ff[DivQW-1] == '0);
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_unit_x      <= zl ? '0 : unit[0];
         rsp_unit_y      <= zl ? '0 : unit[1];
         rsp_unit_z      <= zl ? '0 : unit[2];
         rsp_magnitude   <= MagW'(lend_ff[DivQW-1]);
         rsp_zero_length <= zl;
      end
   end
   assign rsp_valid = out_vld_ff;
endmodule

@@ rtl/core/v3n_checker.sv @@
// Port-level checker for the vector normalize unit, bound to the top level.
// Depends on v3n_pkg and vector3_normalize_unit_assert.svh.
`timescale 1ns / 1ps
`include "vector3_normalize_unit_assert.svh"
module v3n_checker import v3n_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [UnitW-1:0] rsp_unit_x,
   input logic [MagW-1:0]         rsp_magnitude,
   input logic                    rsp_zero_length
);
   `V3N_ASSERT_IMP(a_zero_mag, clock, reset, rsp_valid && rsp_zero_length, rsp_magnitude == '0 && rsp_unit_x == '0)
   `V3N_ASSERT_IMP(a_ready_free, clock, reset, !rsp_valid, req_ready)
   `V3N_ASSERT_IMP(a_unit_rng, clock, reset, rsp_valid, rsp_unit_x <= 16'sd16384 && rsp_unit_x >= -16'sd16384)
   `V3N_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_magnitude))
endmodule

bind vector3_normalize_unit v3n_checker u_v3n_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_unit_x(rsp_unit_x), .rsp_magnitude(rsp_magnitude),
   .rsp_zero_length(rsp_zero_length));

@@ test/vector3_normalize_unit_test.sv @@
// Testbench for vector3_normalize_unit: random and directed vectors, checked
// against an in-bench fixed-point normalize model. Depends on v3n_pkg and the RTL.
`timescale 1ns / 1ps
module vector3_normalize_unit_test;
   import v3n_pkg::*;

   typedef struct packed {
      logic signed [CompW-1:0] x;
      logic signed [CompW-1:0] y;
      logic signed [CompW-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [UnitW-1:0] ux;
      logic signed [UnitW-1:0] uy;
      logic signed [UnitW-1:0] uz;
      logic [MagW-1:0]         mag;
      logic                    zl;
   } norm_type;

   localparam int LATENCY = 44;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CompW-1:0] req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [UnitW-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic [MagW-1:0] rsp_magnitude;
   logic rsp_zero_length;

   vec_type  pending_reqs[$];
   norm_type expected_norms[$];
   int    errors = 0;
   int    sent = 0;
   int    checked = 0;
   int    zero_seen = 0;
   int    send_idle_pct = 0;
   int    recv_stall_pct = 0;
   int    hold_off = 0;
   bit    stim_done = 0;

   vector3_normalize_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic logic [UnitW-1:0] unit_lane(longint signed c, longint unsigned len);
      longint unsigned a;
      longint unsigned q;
      a = (c < 0) ? -c : c;
      q = (a << FracW) / len;
      if (c < 0) q = -q;
      return q[UnitW-1:0];
   endfunction

   function automatic norm_type normalize(vec_type v);
      norm_type r;
      longint signed sx, sy, sz;
      longint unsigned sum, len;
      sx = v.x;
      sy = v.y;
      sz = v.z;
      sum = sx * sx + sy * sy + sz * sz;
      r = '0;
      if (sum == 0) begin
         r.zl = 1'b1;
         return r;
      end
      len = floor_sqrt(sum);
      r.ux = unit_lane(sx, len);
      r.uy = unit_lane(sy, len);
      r.uz = unit_lane(sz, len);
      r.mag = len[MagW-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            vec_type v;
            v = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_comp_x <= v.x;
            req_comp_y <= v.y;
            req_comp_z <= v.z;
            expected_norms.push_back(normalize(v));
            sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_norms.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            norm_type e;
            e = expected_norms.pop_front();
            if (rsp_unit_x !== e.ux) report_mismatch("unit_x", rsp_unit_x, e.ux);
            if (rsp_unit_y !== e.uy) report_mismatch("unit_y", rsp_unit_y, e.uy);
            if (rsp_unit_z !== e.uz) report_mismatch("unit_z", rsp_unit_z, e.uz);
            if (rsp_magnitude !== e.mag) report_mismatch("magnitude", rsp_magnitude, e.mag);
            if (rsp_zero_length !== e.zl)
               report_mismatch("zero_length", rsp_zero_length, e.zl);
            if (e.zl) zero_seen++;
         end
         checked++;
      end
   end

   function automatic logic signed [CompW-1:0] rand_comp();
      case ($urandom_range(5))
         0: return CompW'($urandom_range(7) - 3);
         1: return $signed(CompW'($urandom)) >>> $urandom_range(CompW - 1);
         2: return {1'b1, {(CompW-1){1'b0}}} + CompW'($urandom_range(3));
         3: return {1'b0, {(CompW-1){1'b1}}} - CompW'($urandom_range(3));
         default: return CompW'($urandom);
      endcase
   endfunction

   task automatic push_vec(logic signed [CompW-1:0] x, y, z);
      vec_type v;
      v.x = x;
      v.y = y;
      v.z = z;
      pending_reqs.push_back(v);
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_norms.size() != 0)
         @(posedge clock);
   endtask

   localparam logic signed [CompW-1:0] MAXP = {1'b0, {(CompW-1){1'b1}}};
   localparam logic signed [CompW-1:0] MAXN = {1'b1, {(CompW-1){1'b0}}};

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      push_vec(0, 0, 0);
      push_vec(1, 0, 0);
      push_vec(0, -1, 0);
      push_vec(0, 0, 1);
      push_vec(MAXP, MAXP, MAXP);
      push_vec(MAXN, MAXN, MAXN);
      push_vec(MAXN, 0, 0);
      push_vec(0, MAXN, 0);
      push_vec(0, 0, MAXN);
      push_vec(MAXP, MAXN, 0);
      push_vec(-1, -1, -1);
      push_vec(1, 1, 1);
      push_vec(24'h001000, 24'h001000, 24'h001000);
      push_vec(24'h003000, 24'h004000, 0);
      push_vec(-24'sd3, 24'sd4, 24'sd12);
      push_vec(24'h555555, -24'sh2aaaab, 24'h0f0f0f);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 67 : 12) : 0;
         recv_stall_pct = (phase == 2) ? 67 : (phase == 3 ? 12 : 0);
         if (phase == 0) hold_off <= 300;
         for (int i = 0; i < 330; i++) begin
            push_vec(rand_comp(), rand_comp(), rand_comp());
            if (i % 12 == 0) push_vec(0, 0, 0);
         end
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (LATENCY + 10) @(posedge clock);
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      $display("Covered %0d vectors (%0d zero-length) across idle and stall phases.",
               checked, zero_seen);
      if (errors == 0 && expected_norms.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout after %0d of %0d responses", checked, sent);
      $display("DONE: errors detected");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/v3n_pkg.sv
rtl/core/v3n_sqrt.sv
rtl/core/v3n_div_lane.sv
rtl/core/vector3_normalize_unit.sv
rtl/core/v3n_checker.sv
test/vector3_normalize_unit_test.sv
